// ===== hw/rtl/tltk_pkg.sv =====
// tltk_pkg: shared types and byte constants for the trace line tokenizer
// no dependencies; imported by tltk_step, tltk_out_reg and trace_line_tokenizer_unit
`default_nettype none

package tltk_pkg;

	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 5;
	localparam int INDEX_W  = 4;
	localparam int TOTAL_W  = 5;
	localparam int LINE_W   = 32;
	localparam int STATUS_W = 2;
	localparam int TDATA_W  = 56;
	localparam int TUSER_W  = 2;

	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NL     = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNTERM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// quoting mode of the line scanner
	typedef enum logic [2:0] {
		Q_NONE   = 3'b001,
		Q_SINGLE = 3'b010,
		Q_DOUBLE = 3'b100
	} qmode_t;

	// per-line scanner flags (token count travels apart, its width is a parameter)
	typedef struct packed {
		qmode_t qmode;
		logic   tok_open;
		logic   qbytes;
		logic   ovf;
	} tltk_flags_t;

	typedef struct packed {
		logic                char_valid;
		logic [BYTE_W-1:0]   char_out;
		logic                token_start;
		logic [INDEX_W-1:0]  token_index;
		logic                line_done;
		logic [TOTAL_W-1:0]  token_total;
		logic [LINE_W-1:0]   line_number;
		logic [STATUS_W-1:0] line_status;
	} tltk_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tltk_step.sv =====
// tltk_step: combinational scanner update for one line byte
// depends on tltk_pkg
`default_nettype none

module tltk_step #(
	parameter int MAX_TOKENS = 16,
	parameter int CNT_W      = 5
) (
	input  wire logic [tltk_pkg::BYTE_W-1:0] byte_value,
	input  wire logic                        end_of_line,
	input  wire logic [tltk_pkg::CFG_W-1:0]  max_tokens,
	input  wire tltk_pkg::tltk_flags_t       flags,
	input  wire logic [CNT_W-1:0]            count,
	input  wire logic [tltk_pkg::LINE_W-1:0] lines,
	output tltk_pkg::tltk_flags_t            flags_next,
	output logic [CNT_W-1:0]                 count_next,
	output logic                             emit,
	output tltk_pkg::tltk_result_t           result
);
	import tltk_pkg::*;

	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_TOKENS);

	logic [CMP_W-1:0] cfg_ext;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] cnt_mid_ext;
	logic             is_sep;
	logic             is_quote;
	logic             close_hit;
	logic             open_req;
	logic             open_fail;
	logic             ovf_mid;
	logic [CNT_W-1:0] cnt_mid;
	qmode_t           qm_mid;
	logic             qb_mid;
	logic             open_mid;
	logic             cv;
	logic             ts;
	logic             em;

	always_comb begin
		cfg_ext = CMP_W'(max_tokens);
		if (cfg_ext == '0) begin
			limit = CMP_W'(1);
		end else if (cfg_ext > MAX_CMP) begin
			limit = MAX_CMP;
		end else begin
			limit = cfg_ext;
		end
	end

	assign is_sep = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
	                (byte_value == CH_NUL) || (byte_value == CH_NL);
	assign is_quote = (byte_value == CH_SQUOTE) || (byte_value == CH_DQUOTE);
	assign close_hit = ((flags.qmode == Q_SINGLE) && (byte_value == CH_SQUOTE)) ||
	                   ((flags.qmode == Q_DOUBLE) && (byte_value == CH_DQUOTE));

	// a token opens on a quote or on the first plain byte after a break
	assign open_req  = (flags.qmode == Q_NONE) && !is_sep && (is_quote || !flags.tok_open);
	assign cnt_ext   = CMP_W'(count);
	assign open_fail = flags.ovf || (cnt_ext >= limit);
	assign ovf_mid   = flags.ovf || (open_req && open_fail);
	assign cnt_mid   = count + CNT_W'(open_req && !open_fail);
	assign cnt_mid_ext = CMP_W'(cnt_mid);

	always_comb begin
		qm_mid   = flags.qmode;
		qb_mid   = flags.qbytes;
		open_mid = flags.tok_open;
		cv       = 1'b0;
		ts       = 1'b0;
		em       = 1'b0;
		unique case (flags.qmode) inside
			Q_SINGLE, Q_DOUBLE: begin
				if (close_hit) begin
					if (!flags.ovf && !flags.qbytes) begin
						em = 1'b1;
						ts = 1'b1;
					end
					qm_mid = Q_NONE;
					qb_mid = 1'b0;
				end else begin
					if (!flags.ovf) begin
						em = 1'b1;
						cv = 1'b1;
						ts = !flags.qbytes;
					end
					qb_mid = 1'b1;
				end
			end
			Q_NONE: begin
				if (is_sep) begin
					open_mid = 1'b0;
				end else if (is_quote) begin
					open_mid = 1'b0;
					qm_mid   = (byte_value == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
					qb_mid   = 1'b0;
				end else begin
					if (!ovf_mid) begin
						em = 1'b1;
						cv = 1'b1;
						ts = open_req;
					end
					open_mid = (byte_value != CH_PERCENT);
				end
			end
			default: begin
				qm_mid = Q_NONE;
			end
		endcase
		// a quote still open and empty at line end gets its token start mark here
		if (end_of_line && (qm_mid != Q_NONE) && !qb_mid && !ovf_mid) begin
			ts = 1'b1;
		end
	end

	always_comb begin
		result             = '0;
		result.char_valid  = cv;
		result.char_out    = cv ? byte_value : '0;
		result.token_start = ts;
		result.token_index = (cv || ts) ? INDEX_W'(cnt_mid_ext - CMP_W'(1)) : '0;
		result.line_number = lines + LINE_W'(1);
		if (end_of_line) begin
			result.line_done   = 1'b1;
			result.token_total = TOTAL_W'(cnt_mid_ext);
			if (qm_mid != Q_NONE) begin
				result.line_status = ST_UNTERM;
			end else if (ovf_mid) begin
				result.line_status = ST_OVERFLOW;
			end else begin
				result.line_status = ST_OK;
			end
		end
	end

	assign emit = em || end_of_line;

	always_comb begin
		if (end_of_line) begin
			flags_next = '{qmode: Q_NONE, tok_open: 1'b0, qbytes: 1'b0, ovf: 1'b0};
			count_next = '0;
		end else begin
			flags_next = '{qmode: qm_mid, tok_open: open_mid, qbytes: qb_mid, ovf: ovf_mid};
			count_next = cnt_mid;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tltk_out_reg.sv =====
// tltk_out_reg: result register on the master side of the tokenizer
// depends on tltk_pkg
`default_nettype none

module tltk_out_reg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire tltk_pkg::tltk_result_t din,
	input  wire logic                  take,
	output logic                       busy,
	output tltk_pkg::tltk_result_t     dout
);
	import tltk_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dout <= din;
		end
	end

	assign busy = valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/trace_line_tokenizer_unit.sv =====
// trace_line_tokenizer_unit: top level of the line tokenizer
// depends on tltk_pkg, tltk_step and tltk_out_reg
//
// usage:
//   slave side s_*: one line byte per beat, s_tdata[7:0] the byte, s_tlast on
//   the final byte of each line.
//   master side m_*: one beat per kept token byte, per empty quoted token and
//   per line end. m_tlast marks the line-end beat, which carries token_total,
//   line_status and the line number.
//   cfg_*: write of max_tokens (1..MAX_TOKENS, 0 acts as 1), always ready;
//   write it only while no line byte is in flight.
// path: an accepted byte sits in the input register; once it advances, its
//   result is loaded into the result register, from which it can be taken.
// throughput: one byte per cycle while m_tready is high; the per-byte scanner
//   update is a single step of combinational logic between the input register
//   and the result register, so a byte can enter every cycle.
// stall: while m_tready is low the result register holds; the input register
//   still takes one more byte, then s_tready drops until the result drains.
//   Bytes that give no result leave the input register as soon as the
//   result register can accept.
// reset: arst_n clears the scanner state, the line counter and both valid
//   flags; max_tokens returns to 16. No clearing pass is needed.
`default_nettype none

module trace_line_tokenizer_unit #(
	parameter int MAX_TOKENS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// config write: max_tokens
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tltk_pkg::CFG_W-1:0]   cfg_data,
	// input bytes
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,   // [7:0] byte_value
	input  wire logic                         s_tlast,   // end_of_line
	// results
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [7:0] char_out, [11:8] token_index, [16:12] token_total,
	// [48:17] line_number, [50:49] line_status, [55:51] zero
	output logic [tltk_pkg::TDATA_W-1:0]      m_tdata,
	output logic [tltk_pkg::TUSER_W-1:0]      m_tuser,   // [0] char_valid, [1] token_start
	output logic                              m_tlast    // line_done
);
	import tltk_pkg::*;

	localparam int CNT_W = $clog2(MAX_TOKENS + 1);

	// config register
	logic [CFG_W-1:0] max_tokens_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eol_s1;

	// scanner state
	tltk_flags_t       flags_q;
	logic [CNT_W-1:0]  count_q;
	logic [LINE_W-1:0] lines_q;

	tltk_flags_t       flags_next;
	logic [CNT_W-1:0]  count_next;
	logic              emit;
	tltk_result_t      result;
	tltk_result_t      out_res;
	logic              out_busy;
	logic              advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= CFG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			max_tokens_q <= cfg_data;
		end
	end

	// the byte in the input stage moves on once the result register is free
	assign advance  = valid_s1 && (!out_busy || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
			eol_s1  <= s_tlast;
		end
	end

	tltk_step #(
		.MAX_TOKENS (MAX_TOKENS),
		.CNT_W      (CNT_W)
	) u_step (
		.byte_value  (byte_s1),
		.end_of_line (eol_s1),
		.max_tokens  (max_tokens_q),
		.flags       (flags_q),
		.count       (count_q),
		.lines       (lines_q),
		.flags_next  (flags_next),
		.count_next  (count_next),
		.emit        (emit),
		.result      (result)
	);

	// scanner state commits only when the byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '{qmode: Q_NONE, tok_open: 1'b0, qbytes: 1'b0, ovf: 1'b0};
			count_q <= '0;
			lines_q <= '0;
		end else if (advance) begin
			flags_q <= flags_next;
			count_q <= count_next;
			if (eol_s1) begin
				lines_q <= lines_q + LINE_W'(1);
			end
		end
	end

	tltk_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.din    (result),
		.take   (m_tready),
		.busy   (out_busy),
		.dout   (out_res)
	);

	assign m_tvalid = out_busy;
	assign m_tlast  = out_res.line_done;
	assign m_tuser  = {out_res.token_start, out_res.char_valid};
	assign m_tdata  = {5'd0, out_res.line_status, out_res.line_number,
	                   out_res.token_total, out_res.token_index, out_res.char_out};

	// token count never passes the build-time limit
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(count_q) <= CNT_W'(MAX_TOKENS))
		else $error("token count above MAX_TOKENS");

	// a line end leaves a clean scanner
	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eol_s1 |=> (count_q == '0) && !flags_q.ovf && (flags_q.qmode == Q_NONE))
		else $error("scanner state not cleared at line end");

	// line summary fields stay zero off the line-end beat
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[16:12] == '0) && (m_tdata[50:49] == ST_OK))
		else $error("line summary outside line end");

	// no byte data without char_valid
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == '0))
		else $error("char_out set without char_valid");

	// the input side only stalls behind a held byte
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_busy && !m_tready)
		else $error("input stalled without cause");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for trace_line_tokenizer_unit: streams line bytes, predicts every token beat
// depends on tltk_pkg and the trace_line_tokenizer_unit rtl; self-checking, no files
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tltk_pkg::*;

	localparam int TOKEN_CAP     = 16;
	localparam int SETTLE_CYCLES = 4;       // two register stages plus margin
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_BYTES   = 170;
	localparam int PRINT_CAP     = 40;

	// max_tokens values for the random phases, extremes included
	localparam logic [CFG_W-1:0] LIMIT_SWEEP [8] = '{5'd16, 5'd1, 5'd31, 5'd0,
		5'd2, 5'd15, 5'd8, 5'd5};

	// one line byte waiting for the slave side
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              eol;
	} line_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;    // [7:0] byte_value
	logic                  s_tlast = 1'b0;  // end_of_line
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [7:0] char_out, [11:8] token_index, [16:12] token_total,
	// [48:17] line_number, [50:49] line_status, [55:51] zero
	logic [TDATA_W-1:0]    m_tdata;
	logic [TUSER_W-1:0]    m_tuser;         // [0] char_valid, [1] token_start
	logic                  m_tlast;         // line_done

	trace_line_tokenizer_unit #(
		.MAX_TOKENS(TOKEN_CAP)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// bytes still to send, token beats still to arrive
	line_byte_t   line_bytes_q[$];
	tltk_result_t token_beats_q[$];

	// idle shaping, changed only between phases
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	int mismatch_count = 0;
	int beat_count = 0;
	int cycle_count = 0;

	// shadow of the scanner state and of max_tokens
	qmode_t            scan_mode = Q_NONE;
	logic              in_word = 1'b0;
	logic              quote_has_bytes = 1'b0;
	int                kept_tokens = 0;
	logic              dropped = 1'b0;
	logic [LINE_W-1:0] lines_finished = '0;
	logic [CFG_W-1:0]  max_tokens_shadow = 5'd16;

	line_byte_t   upcoming;
	tltk_result_t seen;
	tltk_result_t wanted;

	initial begin
		forever #5 clk = ~clk;
	end

	// 0 acts as 1, anything above the cap acts as the cap
	function automatic int effective_limit(input logic [CFG_W-1:0] v);
		int lim;
		lim = int'(v);
		if (lim < 1)
			lim = 1;
		if (lim > TOKEN_CAP)
			lim = TOKEN_CAP;
		return lim;
	endfunction

	// once one token of a line is dropped, every later one is too
	function automatic void claim_token();
		if (dropped || kept_tokens >= effective_limit(max_tokens_shadow))
			dropped = 1'b1;
		else
			kept_tokens++;
	endfunction

	// scanner update for one accepted byte; queues the token beat it causes
	function automatic void tokenize_byte(input logic [7:0] b, input logic eol);
		tltk_result_t r;
		logic [7:0]   closer;
		logic         fresh;
		logic         emit;
		r = '0;
		emit = 1'b0;
		r.line_number = lines_finished + 1;
		if (scan_mode != Q_NONE) begin
			closer = (scan_mode == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
			if (b == closer) begin
				// an empty quoted token still gets its start mark here
				if (!dropped && !quote_has_bytes) begin
					emit = 1'b1;
					r.token_start = 1'b1;
				end
				scan_mode = Q_NONE;
				quote_has_bytes = 1'b0;
			end else begin
				if (!dropped) begin
					emit = 1'b1;
					r.char_valid = 1'b1;
					r.char_out = b;
					r.token_start = !quote_has_bytes;
				end
				quote_has_bytes = 1'b1;
			end
		end else if (b == CH_SPACE || b == CH_TAB || b == CH_NUL || b == CH_NL) begin
			in_word = 1'b0;
		end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
			// a quote closes a word that runs into it
			in_word = 1'b0;
			claim_token();
			scan_mode = (b == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
			quote_has_bytes = 1'b0;
		end else begin
			fresh = 1'b0;
			if (!in_word) begin
				claim_token();
				fresh = 1'b1;
			end
			if (!dropped) begin
				emit = 1'b1;
				r.char_valid = 1'b1;
				r.char_out = b;
				r.token_start = fresh;
			end
			// percent is the last byte of its token
			in_word = (b != CH_PERCENT);
		end

		if (eol) begin
			emit = 1'b1;
			r.line_done = 1'b1;
			// quote opened and never filled: start mark rides on the line end
			if (scan_mode != Q_NONE && !quote_has_bytes && !dropped)
				r.token_start = 1'b1;
			// unterminated quote wins over token overflow
			if (scan_mode != Q_NONE)
				r.line_status = ST_UNTERM;
			else if (dropped)
				r.line_status = ST_OVERFLOW;
			else
				r.line_status = ST_OK;
			r.token_total = TOTAL_W'(kept_tokens);
		end

		if (r.char_valid || r.token_start)
			r.token_index = INDEX_W'(kept_tokens - 1);

		if (eol) begin
			scan_mode = Q_NONE;
			in_word = 1'b0;
			quote_has_bytes = 1'b0;
			kept_tokens = 0;
			dropped = 1'b0;
			lines_finished = r.line_number;
		end

		if (emit)
			token_beats_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at result beat %0d: %s", beat_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// ---------------------------------------------------------------
	// driver: presents queued bytes, predicts each one as it is taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				tokenize_byte(s_tdata, s_tlast);
			// the slot is free when nothing is offered or the offer was taken
			if (!s_tvalid || s_tready) begin
				if (line_bytes_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					upcoming = line_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= upcoming.value;
					s_tlast  <= upcoming.eol;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every result beat against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beat_count++;
				seen.char_out    = m_tdata[7:0];
				seen.token_index = m_tdata[11:8];
				seen.token_total = m_tdata[16:12];
				seen.line_number = m_tdata[48:17];
				seen.line_status = m_tdata[50:49];
				seen.char_valid  = m_tuser[0];
				seen.token_start = m_tuser[1];
				seen.line_done   = m_tlast;
				if (token_beats_q.size() == 0) begin
					report_mismatch("result beat with no prediction waiting");
				end else begin
					wanted = token_beats_q.pop_front();
					check_field("char_valid", 32'(seen.char_valid),
						32'(wanted.char_valid));
					check_field("char_out", 32'(seen.char_out), 32'(wanted.char_out));
					check_field("token_start", 32'(seen.token_start),
						32'(wanted.token_start));
					check_field("token_index", 32'(seen.token_index),
						32'(wanted.token_index));
					check_field("line_done", 32'(seen.line_done), 32'(wanted.line_done));
					check_field("token_total", 32'(seen.token_total),
						32'(wanted.token_total));
					check_field("line_number", seen.line_number, wanted.line_number);
					check_field("line_status", 32'(seen.line_status),
						32'(wanted.line_status));
					check_field("tdata padding", 32'(m_tdata[TDATA_W-1:51]), '0);
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d predictions open", cycle_count,
				token_beats_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	function automatic void push_byte(input logic [7:0] value, input logic eol);
		line_byte_t lb;
		lb.value = value;
		lb.eol = eol;
		line_bytes_q.push_back(lb);
	endfunction

	// any byte that neither separates, quotes nor ends a token
	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_TAB || b == CH_NL || b == CH_SPACE || b == CH_SQUOTE
			|| b == CH_DQUOTE || b == CH_PERCENT);
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte(input logic [7:0] closer);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == closer);
		return b;
	endfunction

	function automatic void push_separators();
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(3))
				0: push_byte(CH_SPACE, 1'b0);
				1: push_byte(CH_TAB, 1'b0);
				2: push_byte(CH_NUL, 1'b0);
				default: push_byte(CH_NL, 1'b0);
			endcase
		end
	endfunction

	// one line: mostly well formed token lists, some raw noise
	function automatic void push_line(input int lim);
		int         first;
		int         ntok;
		int         kind;
		int         len;
		logic       unterm;
		logic [7:0] q;
		first = line_bytes_q.size();
		if ($urandom_range(4) == 0) begin
			len = $urandom_range(1, 20);
			repeat (len)
				push_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			// now and then run past the token limit
			if ($urandom_range(3) == 0)
				ntok = $urandom_range(1, lim + 3);
			else
				ntok = $urandom_range(0, (lim < 5) ? lim : 5);
			if ($urandom_range(3) == 0)
				push_separators();
			for (int k = 0; k < ntok; k++) begin
				kind = $urandom_range(0, 5);
				// mostly separated, sometimes glued to the previous token
				if (k > 0 && $urandom_range(3) != 0)
					push_separators();
				unterm = (k == ntok - 1) && ($urandom_range(7) == 0);
				case (kind) inside
					3, 4: begin
						q = (kind == 3) ? CH_SQUOTE : CH_DQUOTE;
						push_byte(q, 1'b0);
						len = $urandom_range(1, 6);
						repeat (len)
							push_byte(quoted_byte(q), 1'b0);
						if (!unterm)
							push_byte(q, 1'b0);
					end
					5: begin
						q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
						push_byte(q, 1'b0);
						if (!unterm)
							push_byte(q, 1'b0);
					end
					default: begin
						len = $urandom_range(1, 6);
						repeat (len)
							push_byte(word_byte(), 1'b0);
						if ($urandom_range(5) == 0)
							push_byte(CH_PERCENT, 1'b0);
					end
				endcase
			end
			if ($urandom_range(3) == 0)
				push_separators();
		end
		if (line_bytes_q.size() == first)
			push_byte(CH_NL, 1'b0);
		line_bytes_q[line_bytes_q.size() - 1].eol = 1'b1;
	endfunction

	// sender holds off until every prediction is met, then lets the
	// input register empty out bytes that give no result
	task automatic wait_drained();
		while (line_bytes_q.size() != 0 || s_tvalid || token_beats_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_tokens(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_tokens_shadow = v;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		logic [CFG_W-1:0] limit_value;
		int               wait_count;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset limit of 16
		// word with a 0xff byte, nul separator, two percent tokens,
		// a word closed by a quote, an empty quote, a quoted byte, a word after it
		push_byte("x", 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(CH_NUL, 1'b0);
		push_byte(CH_PERCENT, 1'b0);
		push_byte(CH_PERCENT, 1'b0);
		push_byte("k", 1'b0);
		push_byte(CH_DQUOTE, 1'b0);
		push_byte(CH_DQUOTE, 1'b0);
		push_byte(CH_SQUOTE, 1'b0);
		push_byte("q", 1'b0);
		push_byte(CH_SQUOTE, 1'b0);
		push_byte("z", 1'b1);
		// unterminated double quote with a tab inside it
		push_byte("a", 1'b0);
		push_byte(CH_DQUOTE, 1'b0);
		push_byte("b", 1'b0);
		push_byte(CH_TAB, 1'b1);
		// line that is only an opening quote
		push_byte(CH_SQUOTE, 1'b1);
		// line with no token at all
		push_byte(CH_NL, 1'b1);
		wait_drained();

		// limit 0 acts as 1: unterminated quote beats overflow,
		// then a line left open across a limit raise
		write_max_tokens(5'd0);
		push_byte("x", 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_SQUOTE, 1'b1);
		push_byte("a", 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte("b", 1'b0);
		wait_drained();

		// above the cap; the open line stays in overflow
		write_max_tokens(5'd31);
		push_byte("c", 1'b1);
		wait_drained();

		// random phases: limit sweep crossed with the idle patterns
		for (int p = 0; p < 8; p++) begin
			limit_value = (p == 7) ? 5'($urandom_range(0, 31)) : LIMIT_SWEEP[p];
			write_max_tokens(limit_value);
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 73;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 73;
				end
				default: begin
					sender_idle_pct = 11;
					receiver_stall_pct = 11;
				end
			endcase
			while (line_bytes_q.size() < PHASE_BYTES)
				push_line(effective_limit(limit_value));
			wait_drained();
		end

		// everything sent; give stragglers a bounded chance
		wait_count = 0;
		while (token_beats_q.size() != 0 && wait_count < 5000) begin
			@(negedge clk);
			wait_count++;
		end
		repeat (8) @(negedge clk);
		if (token_beats_q.size() != 0)
			report_mismatch($sformatf("%0d predicted beats never arrived",
				token_beats_q.size()));

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tltk_pkg.sv
hw/rtl/tltk_step.sv
hw/rtl/tltk_out_reg.sv
hw/rtl/trace_line_tokenizer_unit.sv
test/testbench.sv
